>>> design/assert_macros.svh
// Assertion helpers included by the core top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/eatrm_pkg.sv
// ----------------------------------------------------------------------------
// eatrm_pkg
// Types, constants and the arctangent table for the Euler-to-matrix core.
// ----------------------------------------------------------------------------
`default_nettype none

package eatrm_pkg;

    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int MAX_STAGES    = 32;
    localparam int CW            = 34;   // CORDIC datapath width, Q30 signed

    localparam logic signed [CW-1:0] Q30_PI       = 34'sd3373259426;
    localparam logic signed [CW-1:0] Q30_HALF_PI  = 34'sd1686629713;
    localparam logic signed [CW-1:0] Q30_INV_GAIN = 34'sd652032874;
    localparam logic signed [15:0]   ONE_Q14      = 16'sd16384;

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] angle_x;
        logic signed [ANGLE_WIDTH-1:0] angle_y;
        logic signed [ANGLE_WIDTH-1:0] angle_z;
    } angles_t;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
    } matrix_t;

    typedef struct packed {
        logic signed [15:0] s;
        logic signed [15:0] c;
    } sincos_t;

    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] v;
        case (i)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837830;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            23: v = 34'sd128;
            24: v = 34'sd64;
            25: v = 34'sd32;
            26: v = 34'sd16;
            27: v = 34'sd8;
            28: v = 34'sd4;
            29: v = 34'sd2;
            30: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Clamp a wide signed value to +-1.0 in Q1.14.
    function automatic logic signed [15:0] sat_q14(input logic signed [48:0] v);
        logic signed [15:0] r;
        if (v > 49'sd16384)
            r = ONE_Q14;
        else if (v < -49'sd16384)
            r = -ONE_Q14;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/eatrm_cordic_stage.sv
// ----------------------------------------------------------------------------
// eatrm_cordic_stage
// One registered rotation-mode CORDIC micro-rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module eatrm_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic signed [eatrm_pkg::CW-1:0]  x_in,
    input  wire logic signed [eatrm_pkg::CW-1:0]  y_in,
    input  wire logic signed [eatrm_pkg::CW-1:0]  z_in,
    input  wire logic                             flip_in,
    output logic signed [eatrm_pkg::CW-1:0]       x,
    output logic signed [eatrm_pkg::CW-1:0]       y,
    output logic signed [eatrm_pkg::CW-1:0]       z,
    output logic                                  flip
);

    localparam logic signed [eatrm_pkg::CW-1:0] ATAN = eatrm_pkg::atan_q30(SHIFT);

    logic signed [eatrm_pkg::CW-1:0] x_next, y_next, z_next, xs, ys;

    always_comb
    begin
        xs = x_in >>> SHIFT;
        ys = y_in >>> SHIFT;
        if (!z_in[eatrm_pkg::CW-1])
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x    <= x_next;
            y    <= y_next;
            z    <= z_next;
            flip <= flip_in;
        end
    end

endmodule

`default_nettype wire

>>> design/eatrm_sincos.sv
// ----------------------------------------------------------------------------
// eatrm_sincos
// Range reduction, pipelined CORDIC and Q1.14 rounding for one angle.
// ----------------------------------------------------------------------------
`default_nettype none

module eatrm_sincos #(
    parameter int STAGES = eatrm_pkg::CORDIC_STAGES
) (
    input  wire logic                                      clk,
    input  wire logic                                      en,
    input  wire logic signed [eatrm_pkg::ANGLE_WIDTH-1:0]  angle,
    output eatrm_pkg::sincos_t                             sc
);

    localparam int CW = eatrm_pkg::CW;
    localparam int SH = 33 - eatrm_pkg::ANGLE_WIDTH;

    logic signed [CW-1:0] xs [0:STAGES];
    logic signed [CW-1:0] ys [0:STAGES];
    logic signed [CW-1:0] zs [0:STAGES];
    logic                 fs [0:STAGES];

    logic signed [CW-1:0] a_q30, z_next;
    logic                 flip_next;

    always_comb
    begin
        a_q30     = CW'(angle) <<< SH;
        z_next    = a_q30;
        flip_next = 1'b0;
        if (a_q30 > eatrm_pkg::Q30_HALF_PI)
        begin
            z_next    = a_q30 - eatrm_pkg::Q30_PI;
            flip_next = 1'b1;
        end
        else if (a_q30 < -eatrm_pkg::Q30_HALF_PI)
        begin
            z_next    = a_q30 + eatrm_pkg::Q30_PI;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xs[0] <= eatrm_pkg::Q30_INV_GAIN;
            ys[0] <= '0;
            zs[0] <= z_next;
            fs[0] <= flip_next;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        eatrm_cordic_stage #(.SHIFT(i)) u_stage (
            .clk     (clk),
            .en      (en),
            .x_in    (xs[i]),
            .y_in    (ys[i]),
            .z_in    (zs[i]),
            .flip_in (fs[i]),
            .x       (xs[i+1]),
            .y       (ys[i+1]),
            .z       (zs[i+1]),
            .flip    (fs[i+1])
        );
    end

    // Negate before rounding, then round half up to Q14.
    logic signed [CW:0] xr, yr;
    eatrm_pkg::sincos_t sc_next;

    always_comb
    begin
        xr = fs[STAGES] ? -(CW+1)'(xs[STAGES]) : (CW+1)'(xs[STAGES]);
        yr = fs[STAGES] ? -(CW+1)'(ys[STAGES]) : (CW+1)'(ys[STAGES]);
        xr = (xr + (CW+1)'(32768)) >>> 16;
        yr = (yr + (CW+1)'(32768)) >>> 16;
        sc_next.c = eatrm_pkg::sat_q14(49'(xr));
        sc_next.s = eatrm_pkg::sat_q14(49'(yr));
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sc <= sc_next;
    end

endmodule

`default_nettype wire

>>> design/eatrm_matrix.sv
// ----------------------------------------------------------------------------
// eatrm_matrix
// Three-stage product tree forming R = Rz*Ry*Rx from Q1.14 sines and cosines.
// ----------------------------------------------------------------------------
`default_nettype none

module eatrm_matrix (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire eatrm_pkg::sincos_t scx,
    input  wire eatrm_pkg::sincos_t scy,
    input  wire eatrm_pkg::sincos_t scz,
    output eatrm_pkg::matrix_t      m
);

    // stage 1: pairwise products
    logic signed [31:0] czsy_reg, szsy_reg;
    logic signed [31:0] czcy_reg, szcy_reg, cysx_reg, cycx_reg;
    logic signed [31:0] szcx_reg, szsx_reg, czcx_reg, czsx_reg;
    logic signed [15:0] sx_reg, cx_reg, nsy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            czsy_reg <= scz.c * scy.s;
            szsy_reg <= scz.s * scy.s;
            czcy_reg <= scz.c * scy.c;
            szcy_reg <= scz.s * scy.c;
            cysx_reg <= scy.c * scx.s;
            cycx_reg <= scy.c * scx.c;
            szcx_reg <= scz.s * scx.c;
            szsx_reg <= scz.s * scx.s;
            czcx_reg <= scz.c * scx.c;
            czsx_reg <= scz.c * scx.s;
            sx_reg   <= scx.s;
            cx_reg   <= scx.c;
            nsy_reg  <= -scy.s;
        end
    end

    // stage 2: three-factor terms plus scaled two-factor terms, Q42
    logic signed [48:0] s01_reg, s02_reg, s11_reg, s12_reg;
    logic signed [31:0] p00_reg, p10_reg, p21_reg, p22_reg;
    logic signed [15:0] r20_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s01_reg <= 49'(czsy_reg) * 49'(sx_reg) - (49'(szcx_reg) <<< 14);
            s02_reg <= 49'(czsy_reg) * 49'(cx_reg) + (49'(szsx_reg) <<< 14);
            s11_reg <= 49'(szsy_reg) * 49'(sx_reg) + (49'(czcx_reg) <<< 14);
            s12_reg <= 49'(szsy_reg) * 49'(cx_reg) - (49'(czsx_reg) <<< 14);
            p00_reg <= czcy_reg;
            p10_reg <= szcy_reg;
            p21_reg <= cysx_reg;
            p22_reg <= cycx_reg;
            r20_reg <= nsy_reg;
        end
    end

    // stage 3: round once and saturate
    function automatic logic signed [15:0] rnd28(input logic signed [48:0] v);
        logic signed [48:0] t;
        t = (v + 49'sd134217728) >>> 28;
        return eatrm_pkg::sat_q14(t);
    endfunction

    function automatic logic signed [15:0] rnd14(input logic signed [31:0] v);
        logic signed [48:0] t;
        t = (49'(v) + 49'sd8192) >>> 14;
        return eatrm_pkg::sat_q14(t);
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m.r00 <= rnd14(p00_reg);
            m.r01 <= rnd28(s01_reg);
            m.r02 <= rnd28(s02_reg);
            m.r10 <= rnd14(p10_reg);
            m.r11 <= rnd28(s11_reg);
            m.r12 <= rnd28(s12_reg);
            m.r20 <= r20_reg;
            m.r21 <= rnd14(p21_reg);
            m.r22 <= rnd14(p22_reg);
        end
    end

endmodule

`default_nettype wire

>>> design/euler_angles_to_rotation_matrix_core.sv
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix_core
// ZYX Euler angles (Q2.13 rad) to a 3x3 rotation matrix in Q1.14.
// ----------------------------------------------------------------------------
// Fully pipelined: one angle triple is taken every cycle unless a valid
// output is stalled. Each triple passes through range reduction, the unrolled
// CORDIC chain (one micro-rotation per register stage), Q14 rounding and a
// three-stage multiplier tree. An output stall while matrix_valid is high
// freezes the whole pipeline; angle_stall follows it directly.
`default_nettype none
`include "assert_macros.svh"

module euler_angles_to_rotation_matrix_core #(
    parameter int CORDIC_STAGES = eatrm_pkg::CORDIC_STAGES
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               angle_valid,
    output logic                    angle_stall,
    input  wire eatrm_pkg::angles_t angle,
    output logic                    matrix_valid,
    input  wire logic               matrix_stall,
    output eatrm_pkg::matrix_t      matrix
);

    localparam int N   = (CORDIC_STAGES > eatrm_pkg::MAX_STAGES) ?
                         eatrm_pkg::MAX_STAGES : CORDIC_STAGES;
    localparam int LAT = N + 5;

    logic [LAT-1:0] vld_reg, vld_next;
    logic           adv;

    assign adv         = !(vld_reg[LAT-1] && matrix_stall);
    assign angle_stall = !adv;

    always_comb
    begin
        vld_next = {vld_reg[LAT-2:0], angle_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    eatrm_pkg::sincos_t scx, scy, scz;

    eatrm_sincos #(.STAGES(N)) u_sc_x (
        .clk(clk), .en(adv), .angle(angle.angle_x), .sc(scx));
    eatrm_sincos #(.STAGES(N)) u_sc_y (
        .clk(clk), .en(adv), .angle(angle.angle_y), .sc(scy));
    eatrm_sincos #(.STAGES(N)) u_sc_z (
        .clk(clk), .en(adv), .angle(angle.angle_z), .sc(scz));

    eatrm_matrix u_matrix (
        .clk(clk), .en(adv), .scx(scx), .scy(scy), .scz(scz), .m(matrix));

    assign matrix_valid = vld_reg[LAT-1];

    logic r00_in_range;
    assign r00_in_range = (matrix.r00 <= 16'sd16384) && (matrix.r00 >= -16'sd16384);

    `ASSERT_NEXT(a_accept_enters, clk, rst_n, angle_valid && !angle_stall, vld_reg[0])
    `ASSERT_NEXT(a_stall_freezes, clk, rst_n, matrix_valid && matrix_stall, $stable(vld_reg))
    `ASSERT_IMPLIES(a_r00_range, clk, rst_n, matrix_valid, r00_in_range)

endmodule

`default_nettype wire

>>> sim/tb_euler_angles_to_rotation_matrix_core.sv
// ----------------------------------------------------------------------------
// tb_euler_angles_to_rotation_matrix_core
// Drives angle triples through the core and checks every matrix entry against
// a bit-exact CORDIC and multiply predictor, under several idle/stall phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_euler_angles_to_rotation_matrix_core;

    localparam int LATENCY = ((eatrm_pkg::CORDIC_STAGES > 32) ? 32 :
                              eatrm_pkg::CORDIC_STAGES) + 5;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic angle_valid = 1'b0;
    logic angle_stall;
    eatrm_pkg::angles_t angle = '0;
    logic matrix_valid;
    logic matrix_stall = 1'b0;
    eatrm_pkg::matrix_t matrix;

    eatrm_pkg::matrix_t expected_matrices[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    euler_angles_to_rotation_matrix_core dut (
        .clk(clk), .rst_n(rst_n),
        .angle_valid(angle_valid), .angle_stall(angle_stall), .angle(angle),
        .matrix_valid(matrix_valid), .matrix_stall(matrix_stall), .matrix(matrix)
    );

    always #2 clk = ~clk;

    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_one(longint v);
        if (v > 16384)
            return 16384;
        if (v < -16384)
            return -16384;
        return v;
    endfunction

    function automatic longint atan_entry(int i);
        longint t[32] = '{843314857, 497837830, 263043837, 133525159,
            67021687, 33543516, 16775851, 8388437, 4194283, 2097149,
            1048576, 524288, 262144, 131072, 65536, 32768, 16384, 8192,
            4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};
        return t[i];
    endfunction

    task automatic sin_cos(input logic signed [eatrm_pkg::ANGLE_WIDTH-1:0] raw,
                           output longint s, output longint c);
        longint a, x, y, z, xs, ys;
        bit flip;
        int n;
        a = longint'(raw) * (longint'(1) << (33 - eatrm_pkg::ANGLE_WIDTH));
        flip = 0;
        if (a > 64'sd1686629713)
        begin
            a -= 64'sd3373259426;
            flip = 1;
        end
        else if (a < -64'sd1686629713)
        begin
            a += 64'sd3373259426;
            flip = 1;
        end
        x = 652032874;
        y = 0;
        z = a;
        n = (eatrm_pkg::CORDIC_STAGES > 32) ? 32 : eatrm_pkg::CORDIC_STAGES;
        for (int i = 0; i < n; i++)
        begin
            xs = fl_shift(x, i);
            ys = fl_shift(y, i);
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= atan_entry(i);
            end
            else
            begin
                x += ys;
                y -= xs;
                z += atan_entry(i);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = clamp_one(rnd_shift(x, 16));
        s = clamp_one(rnd_shift(y, 16));
    endtask

    function automatic longint mul2(longint a, longint b);
        return clamp_one(rnd_shift(a * b, 14));
    endfunction

    function automatic longint mul3_sum(longint a, longint b, longint c,
                                        longint d, longint e, bit add);
        longint t3, t2;
        t3 = a * b * c;
        t2 = d * e * 16384;
        return clamp_one(rnd_shift(add ? t3 + t2 : t3 - t2, 28));
    endfunction

    task automatic predict_matrix(input eatrm_pkg::angles_t a,
                                  output eatrm_pkg::matrix_t m);
        longint sx, cx, sy, cy, sz, cz;
        sin_cos(a.angle_x, sx, cx);
        sin_cos(a.angle_y, sy, cy);
        sin_cos(a.angle_z, sz, cz);
        m.r00 = 16'(mul2(cz, cy));
        m.r01 = 16'(mul3_sum(cz, sy, sx, sz, cx, 0));
        m.r02 = 16'(mul3_sum(cz, sy, cx, sz, sx, 1));
        m.r10 = 16'(mul2(sz, cy));
        m.r11 = 16'(mul3_sum(sz, sy, sx, cz, cx, 1));
        m.r12 = 16'(mul3_sum(sz, sy, cx, cz, sx, 0));
        m.r20 = 16'(clamp_one(-sy));
        m.r21 = 16'(mul2(cy, sx));
        m.r22 = 16'(mul2(cy, cx));
    endtask

    // One transaction; valid stays high across back-to-back items.
    task automatic send_angles(input eatrm_pkg::angles_t a);
        eatrm_pkg::matrix_t m;
        predict_matrix(a, m);
        while ($urandom_range(99) < send_idle_pct)
        begin
            angle_valid <= 1'b0;
            @(posedge clk);
        end
        angle <= a;
        angle_valid <= 1'b1;
        expected_matrices.push_back(m);
        @(posedge clk);
        while (angle_stall)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            matrix_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && matrix_valid && !matrix_stall)
        begin
            if (expected_matrices.size() == 0)
            begin
                $display("%0t: unexpected matrix %h", $time, matrix);
                errors++;
            end
            else
            begin
                eatrm_pkg::matrix_t e;
                e = expected_matrices.pop_front();
                for (int k = 0; k < 9; k++)
                    if (e[16*k +: 16] !== matrix[16*k +: 16])
                    begin
                        $display("%0t: entry %0d expected %0d actual %0d", $time, 8 - k,
                                 $signed(e[16*k +: 16]), $signed(matrix[16*k +: 16]));
                        errors++;
                    end
            end
        end
    end

    function automatic logic [15:0] pick_angle();
        logic [15:0] edges[10] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff,
            16'd12868, -16'sd12868, 16'd12869, -16'sd12869, 16'd25736, -16'sd25736};
        if ($urandom_range(7) == 0)
            return edges[$urandom_range(9)];
        return 16'($urandom);
    endfunction

    task automatic test_directed();
        logic [15:0] v[10] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'd12868,
            -16'sd12868, 16'd12869, -16'sd12869, 16'd25736, 16'h5555};
        for (int i = 0; i < 10; i++)
        begin
            send_angles('{v[i], 16'h0000, 16'h0000});
            send_angles('{16'h0000, v[i], 16'h0000});
        end
        send_angles('{16'h7fff, 16'h8000, 16'haaaa});
        send_angles('{16'h8000, 16'h7fff, 16'h5555});
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count)
            send_angles('{pick_angle(), pick_angle(), pick_angle()});
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(325, 0, 0);
        test_random(325, 45, 0);
        test_random(325, 0, 45);
        test_random(325, 12, 12);
        angle_valid <= 1'b0;
        recv_stall_pct = 0;
        while (expected_matrices.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("tb_euler_angles_to_rotation_matrix_core: done, clean");
        else
            $display("tb_euler_angles_to_rotation_matrix_core: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_euler_angles_to_rotation_matrix_core: done, errors");
        $finish;
    end
endmodule

>>> files.f
+incdir+design
design/eatrm_pkg.sv
design/eatrm_cordic_stage.sv
design/eatrm_sincos.sv
design/eatrm_matrix.sv
design/euler_angles_to_rotation_matrix_core.sv
sim/tb_euler_angles_to_rotation_matrix_core.sv
